/* hw/rtl/ohm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the open addressing hash map unit.
// No dependencies; used by every module of the block except ohm_ram.
package ohm_pkg;

    // Default table geometry
    localparam int DEF_MAX_BITS   = 10;
    localparam int DEF_START_BITS = 2;

    // Fixed field widths
    localparam int KEY_BITS      = 32;
    localparam int VALUE_BITS    = 32;
    localparam int MULT_BITS     = 64;
    localparam int LIVE_BITS     = 11;
    localparam int OP_BITS       = 2;
    localparam int STATUS_BITS   = 2;
    localparam int TAG_BITS      = 2;
    localparam int IN_DATA_BITS  = KEY_BITS + VALUE_BITS;
    localparam int OUT_USED_BITS = 1 + VALUE_BITS + LIVE_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    // Two to the 64 divided by the golden ratio
    localparam logic [MULT_BITS-1:0] MULT_RESET = 64'h9E37_79B9_7F4A_7C15;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_KEY_ZERO = 2'd2
    } status_t;

    typedef enum logic [TAG_BITS-1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_DEAD  = 2'd2
    } tag_t;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_CLR,
        S_HMUL,
        S_HOME,
        S_FRD,
        S_FCHK,
        S_CLEANUP,
        S_INS_FREE,
        S_RH_CLR,
        S_RH_RD,
        S_RH_CHK,
        S_RH_NEXT,
        S_PRD,
        S_PCHK,
        S_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic map_reset;
        logic hash_mul;
        logic hash_home;
        logic use_dst;
        logic rd;
        logic probe_eval;
        logic probe_adv;
        logic wr_live;
        logic wr_update;
        logic wr_dead;
        logic wr_free;
        logic clr_wr;
        logic rh_init;
        logic rh_grow;
        logic rh_rd;
        logic rh_next;
        logic rh_commit;
        logic load_work_item;
        logic load_work_mem;
        logic set_found;
        logic cap_value;
        logic set_full;
        logic out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  in_op;
        logic in_key_zero;
        op_t  item_op;
        logic tag_empty;
        logic tag_live;
        logic key_match;
        logic probe_last;
        logic free_valid;
        logic clr_last;
        logic rh_last;
        logic need_grow;
        logic need_same;
        logic at_max;
    } dp_stat_t;

endpackage

/* hw/rtl/ohm_ram.sv */
`timescale 1ns / 1ps
// Generic single write, single read RAM with registered read data.
// No dependencies.
module ohm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ohm_dp.sv */
`timescale 1ns / 1ps
// Datapath of the hash map: slot RAM, hash multiplier, probe and rehash
// counters, occupancy counters and result registers. Uses ohm_pkg, ohm_ram.
module ohm_dp import ohm_pkg::*; #(
    parameter int MAX_BITS   = DEF_MAX_BITS,
    parameter int START_BITS = DEF_START_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MULT_BITS-1:0]   cfg_data,
    // request fields
    input  logic [OP_BITS-1:0]     in_op,
    input  logic [KEY_BITS-1:0]    in_key,
    input  logic [VALUE_BITS-1:0]  in_value,
    // control
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    // result fields
    output logic                   found,
    output logic [VALUE_BITS-1:0]  value_out,
    output logic [STATUS_BITS-1:0] status,
    output logic [LIVE_BITS-1:0]   live_count
);

    localparam int TBITS = (START_BITS > MAX_BITS) ? START_BITS : MAX_BITS;
    localparam int SB    = $clog2(TBITS + 1);
    localparam int CW    = TBITS + 1;
    localparam int AW    = TBITS + 1;
    localparam int DW    = TAG_BITS + KEY_BITS + VALUE_BITS;
    localparam int HW    = MULT_BITS / 2;

    function automatic logic [TBITS-1:0] slot_mask(input logic [SB-1:0] b);
        return {TBITS{1'b1}} >> (SB'(TBITS) - b);
    endfunction

    // control registers
    logic [MULT_BITS-1:0] mult_reg;
    logic                 bank_reg;
    logic                 dst_bank_reg;
    logic [SB-1:0]        size_bits_reg;
    logic [SB-1:0]        new_bits_reg;
    logic [CW-1:0]        used_reg;
    logic [CW-1:0]        deleted_reg;
    logic [TBITS-1:0]     cidx_reg;
    logic [TBITS-1:0]     ridx_reg;
    logic                 free_valid_reg;

    // payload registers
    op_t                  item_op_reg;
    logic [KEY_BITS-1:0]  item_key_reg;
    logic [VALUE_BITS-1:0] item_val_reg;
    logic [KEY_BITS-1:0]  wk_key_reg;
    logic [VALUE_BITS-1:0] wk_val_reg;
    logic [2*HW-1:0]      p0_reg;
    logic [HW-1:0]        p1_reg;
    logic [TBITS-1:0]     idx_reg;
    logic [TBITS-1:0]     n_reg;
    logic [TBITS-1:0]     free_idx_reg;
    tag_t                 free_tag_reg;
    logic                 found_reg;
    logic [VALUE_BITS-1:0] vout_reg;
    status_t              status_reg;
    logic                 out_found_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    status_t              out_status_reg;
    logic [LIVE_BITS-1:0] out_live_reg;

    // RAM ports
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [DW-1:0]        wdata;
    logic                 re;
    logic [AW-1:0]        raddr;
    logic [DW-1:0]        rdata;

    // decoded read word and helpers
    tag_t                 rd_tag;
    logic [KEY_BITS-1:0]  rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [SB-1:0]        bits_sel;
    logic                 bank_sel;
    logic [TBITS-1:0]     mask_sel;
    logic [HW-1:0]        sum_hi;
    logic [TBITS-1:0]     home;
    tag_t                 place_tag;
    logic [CW+1:0]        load_u;
    logic [CW+1:0]        load_u3;
    logic [CW+1:0]        size2;

    ohm_ram #(
        .WIDTH (DW),
        .DEPTH (2 ** AW)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cfg_ready = 1'b1;

    assign rd_tag   = tag_t'(rdata[DW-1 -: TAG_BITS]);
    assign rd_key   = rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign rd_val   = rdata[VALUE_BITS-1:0];
    assign bits_sel = cmd.use_dst ? new_bits_reg : size_bits_reg;
    assign bank_sel = cmd.use_dst ? dst_bank_reg : bank_reg;
    assign mask_sel = slot_mask(bits_sel);

    // home slot: top bits of the low 64 bits of key * multiplier
    assign sum_hi = p0_reg[2*HW-1:HW] + p1_reg;
    assign home   = sum_hi[HW-1 -: TBITS] >> (SB'(TBITS) - bits_sel);

    // RAM write port select
    always_comb
    begin
        we    = 1'b0;
        waddr = {bank_sel, idx_reg};
        wdata = {TAG_LIVE, wk_key_reg, wk_val_reg};
        priority if (cmd.clr_wr)
        begin
            we    = 1'b1;
            waddr = {dst_bank_reg, cidx_reg};
            wdata = {TAG_EMPTY, {KEY_BITS{1'b0}}, {VALUE_BITS{1'b0}}};
        end
        else if (cmd.wr_free)
        begin
            we    = 1'b1;
            waddr = {bank_reg, free_idx_reg};
        end
        else if (cmd.wr_dead)
        begin
            we    = 1'b1;
            wdata = {TAG_DEAD, wk_key_reg, {VALUE_BITS{1'b0}}};
        end
        else if (cmd.wr_live || cmd.wr_update)
        begin
            we = 1'b1;
        end
    end

    // RAM read port select
    assign re    = cmd.rd | cmd.rh_rd;
    assign raddr = cmd.rh_rd ? {bank_reg, ridx_reg} : {bank_sel, idx_reg};

    // load checks
    assign load_u  = (CW+2)'(used_reg) + (CW+2)'(item_op_reg == OP_INSERT);
    assign load_u3 = load_u + (load_u << 1);
    assign size2   = ((CW+2)'(1) << size_bits_reg) << 1;

    assign place_tag = cmd.wr_free ? free_tag_reg : rd_tag;

    // status to controller
    always_comb
    begin
        stat.in_op       = op_t'(in_op);
        stat.in_key_zero = (in_key == '0);
        stat.item_op     = item_op_reg;
        stat.tag_empty   = (rd_tag == TAG_EMPTY);
        stat.tag_live    = (rd_tag == TAG_LIVE);
        stat.key_match   = (rd_key == wk_key_reg);
        stat.probe_last  = (n_reg == mask_sel);
        stat.free_valid  = free_valid_reg;
        stat.clr_last    = (cidx_reg == slot_mask(new_bits_reg));
        stat.rh_last     = (ridx_reg == slot_mask(size_bits_reg));
        stat.need_grow   = (load_u3 >= size2);
        stat.need_same   = (deleted_reg != '0) && ((CW+2)'(deleted_reg) >= load_u);
        stat.at_max      = (32'(size_bits_reg) >= MAX_BITS);
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= MULT_RESET;
        end
        else if (cfg_valid)
        begin
            mult_reg <= cfg_data;
        end
    end

    // table geometry and bank select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg      <= 1'b0;
            dst_bank_reg  <= 1'b0;
            size_bits_reg <= SB'(START_BITS);
            new_bits_reg  <= SB'(START_BITS);
        end
        else if (cmd.map_reset)
        begin
            bank_reg      <= 1'b0;
            dst_bank_reg  <= 1'b0;
            size_bits_reg <= SB'(START_BITS);
            new_bits_reg  <= SB'(START_BITS);
        end
        else if (cmd.rh_init)
        begin
            dst_bank_reg <= ~bank_reg;
            new_bits_reg <= size_bits_reg + SB'(cmd.rh_grow);
        end
        else if (cmd.rh_commit)
        begin
            bank_reg      <= dst_bank_reg;
            size_bits_reg <= new_bits_reg;
        end
    end

    // occupancy counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            deleted_reg <= '0;
        end
        else if (cmd.map_reset || cmd.rh_init)
        begin
            used_reg    <= '0;
            deleted_reg <= '0;
        end
        else if (cmd.wr_live || cmd.wr_free)
        begin
            used_reg <= used_reg + CW'(1);
            if (place_tag == TAG_DEAD && deleted_reg != '0)
            begin
                deleted_reg <= deleted_reg - CW'(1);
            end
        end
        else if (cmd.wr_dead)
        begin
            if (used_reg != '0)
            begin
                used_reg <= used_reg - CW'(1);
            end
            deleted_reg <= deleted_reg + CW'(1);
        end
    end

    // clear-pass and rehash-source walkers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cidx_reg <= '0;
            ridx_reg <= '0;
        end
        else
        begin
            if (cmd.map_reset || cmd.rh_init)
            begin
                cidx_reg <= '0;
            end
            else if (cmd.clr_wr)
            begin
                cidx_reg <= cidx_reg + TBITS'(1);
            end
            if (cmd.rh_init)
            begin
                ridx_reg <= '0;
            end
            else if (cmd.rh_next)
            begin
                ridx_reg <= ridx_reg + TBITS'(1);
            end
        end
    end

    // first non-live slot on the probe path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_valid_reg <= 1'b0;
        end
        else if (cmd.hash_home)
        begin
            free_valid_reg <= 1'b0;
        end
        else if (cmd.probe_eval && !free_valid_reg && rd_tag != TAG_LIVE)
        begin
            free_valid_reg <= 1'b1;
        end
    end

    // payload: request, work key, hash, probe, results
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_op_reg  <= op_t'(in_op);
            item_key_reg <= in_key;
            item_val_reg <= in_value;
            wk_key_reg   <= in_key;
            wk_val_reg   <= in_value;
            found_reg    <= 1'b0;
            vout_reg     <= '0;
            status_reg   <= (in_key == '0 && op_t'(in_op) != OP_CLEAR) ? ST_KEY_ZERO : ST_OK;
        end
        else
        begin
            if (cmd.load_work_item)
            begin
                wk_key_reg <= item_key_reg;
                wk_val_reg <= item_val_reg;
            end
            else if (cmd.load_work_mem)
            begin
                wk_key_reg <= rd_key;
                wk_val_reg <= rd_val;
            end
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.cap_value)
            begin
                vout_reg <= rd_val;
            end
            if (cmd.set_full)
            begin
                status_reg <= ST_FULL;
            end
        end

        if (cmd.hash_mul)
        begin
            p0_reg <= (2*HW)'(wk_key_reg) * (2*HW)'(mult_reg[HW-1:0]);
            p1_reg <= wk_key_reg * mult_reg[MULT_BITS-1:HW];
        end

        if (cmd.hash_home)
        begin
            idx_reg <= home;
            n_reg   <= '0;
        end
        else if (cmd.probe_adv)
        begin
            idx_reg <= (idx_reg + TBITS'(1)) & mask_sel;
            n_reg   <= n_reg + TBITS'(1);
        end

        if (cmd.probe_eval && !free_valid_reg && rd_tag != TAG_LIVE)
        begin
            free_idx_reg <= idx_reg;
            free_tag_reg <= rd_tag;
        end

        if (cmd.out_load)
        begin
            out_found_reg  <= found_reg;
            out_value_reg  <= vout_reg;
            out_status_reg <= status_reg;
            out_live_reg   <= LIVE_BITS'(used_reg);
        end
    end

    assign found      = out_found_reg;
    assign value_out  = out_value_reg;
    assign status     = out_status_reg;
    assign live_count = out_live_reg;

endmodule

/* hw/rtl/ohm_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the hash map: sequences probe, insert, remove, clear and
// rehash steps and owns the request/result handshakes. Uses ohm_pkg.
module ohm_ctrl import ohm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   rh_active_reg;
    logic   rh_active_next;
    logic   place_reg;
    logic   place_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;
    logic   hit;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign hit      = stat.tag_live && stat.key_match;

    // next state
    always_comb
    begin
        state_next     = state_reg;
        rh_active_next = rh_active_reg;
        place_next     = place_reg;
        unique case (state_reg)
            S_INIT_CLR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    place_next = 1'b0;
                    priority if (stat.in_op == OP_CLEAR)
                    begin
                        state_next = S_CLR;
                    end
                    else if (stat.in_key_zero)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_HMUL;
                    end
                end
            end
            S_CLR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_HMUL:
            begin
                state_next = S_HOME;
            end
            S_HOME:
            begin
                state_next = place_reg ? S_PRD : S_FRD;
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                priority if (hit)
                begin
                    state_next = (stat.item_op == OP_REMOVE) ? S_CLEANUP : S_RESP;
                end
                else if (stat.tag_empty || stat.probe_last)
                begin
                    state_next = (stat.item_op == OP_INSERT) ? S_CLEANUP : S_RESP;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_CLEANUP:
            begin
                priority if (stat.need_grow)
                begin
                    if (stat.at_max)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        rh_active_next = 1'b1;
                        state_next     = S_RH_CLR;
                    end
                end
                else if (stat.need_same)
                begin
                    rh_active_next = 1'b1;
                    state_next     = S_RH_CLR;
                end
                else
                begin
                    state_next = (stat.item_op == OP_INSERT) ? S_INS_FREE : S_RESP;
                end
            end
            S_INS_FREE:
            begin
                state_next = S_RESP;
            end
            S_RH_CLR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_RH_RD;
                end
            end
            S_RH_RD:
            begin
                state_next = S_RH_CHK;
            end
            S_RH_CHK:
            begin
                if (stat.tag_live)
                begin
                    place_next = 1'b1;
                    state_next = S_HMUL;
                end
                else
                begin
                    state_next = S_RH_NEXT;
                end
            end
            S_RH_NEXT:
            begin
                if (stat.rh_last)
                begin
                    rh_active_next = 1'b0;
                    if (stat.item_op == OP_INSERT)
                    begin
                        place_next = 1'b1;
                        state_next = S_HMUL;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    state_next = S_RH_RD;
                end
            end
            S_PRD:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (!stat.tag_live || stat.probe_last)
                begin
                    state_next = rh_active_reg ? S_RH_NEXT : S_RESP;
                end
                else
                begin
                    state_next = S_PRD;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd         = '0;
        cmd.use_dst = rh_active_reg;
        unique case (state_reg)
            S_INIT_CLR, S_CLR, S_RH_CLR:
            begin
                cmd.clr_wr = 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    cmd.map_reset = (stat.in_op == OP_CLEAR);
                end
            end
            S_HMUL:
            begin
                cmd.hash_mul = 1'b1;
            end
            S_HOME:
            begin
                cmd.hash_home = 1'b1;
            end
            S_FRD, S_PRD:
            begin
                cmd.rd = 1'b1;
            end
            S_FCHK:
            begin
                cmd.probe_eval = 1'b1;
                priority if (hit)
                begin
                    cmd.set_found = 1'b1;
                    cmd.cap_value = (stat.item_op == OP_LOOKUP);
                    cmd.wr_update = (stat.item_op == OP_INSERT);
                    cmd.wr_dead   = (stat.item_op == OP_REMOVE);
                end
                else if (!stat.tag_empty && !stat.probe_last)
                begin
                    cmd.probe_adv = 1'b1;
                end
            end
            S_CLEANUP:
            begin
                priority if (stat.need_grow)
                begin
                    if (stat.at_max)
                    begin
                        cmd.set_full = (stat.item_op == OP_INSERT);
                    end
                    else
                    begin
                        cmd.rh_init = 1'b1;
                        cmd.rh_grow = 1'b1;
                    end
                end
                else if (stat.need_same)
                begin
                    cmd.rh_init = 1'b1;
                end
            end
            S_INS_FREE:
            begin
                cmd.wr_free = stat.free_valid;
            end
            S_RH_RD:
            begin
                cmd.rh_rd = 1'b1;
            end
            S_RH_CHK:
            begin
                cmd.load_work_mem = stat.tag_live;
            end
            S_RH_NEXT:
            begin
                if (stat.rh_last)
                begin
                    cmd.rh_commit      = 1'b1;
                    cmd.load_work_item = (stat.item_op == OP_INSERT);
                end
                else
                begin
                    cmd.rh_next = 1'b1;
                end
            end
            S_PCHK:
            begin
                if (!stat.tag_live)
                begin
                    cmd.wr_live = 1'b1;
                end
                else if (!stat.probe_last)
                begin
                    cmd.probe_adv = 1'b1;
                end
            end
            S_RESP:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.use_dst = rh_active_reg;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT_CLR;
            rh_active_reg <= 1'b0;
            place_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rh_active_reg <= rh_active_next;
            place_reg     <= place_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/open_addressing_hash_map_unit.sv */
`timescale 1ns / 1ps
// A lookup or update hashes the key, then reads and checks each probed slot; a remove
// hit adds a cleanup step, an insert of a new key adds cleanup and a free-slot write.
// Clear empties 2^START_BITS slots. A rehash clears 2^new_bits slots, then walks the old
// table, placing each live entry anew and stalling requests; an insert then places its
// key. One request in flight; the next is taken in the cycle after the result loads.
// Reset: empty map of 2^START_BITS slots after a clearing pass; golden ratio multiplier.
module open_addressing_hash_map_unit import ohm_pkg::*; #(
    parameter int MAX_BITS   = DEF_MAX_BITS,
    parameter int START_BITS = DEF_START_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // request stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // key, value
    input  logic [OP_BITS-1:0]       s_axis_tuser,  // op
    // result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // found, value_out, live_count, zero pad
    output logic [STATUS_BITS-1:0]   m_axis_tuser,  // status
    // multiplier write
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [MULT_BITS-1:0]     cfg_data
);

    localparam int TBITS = (START_BITS > MAX_BITS) ? START_BITS : MAX_BITS;

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic [LIVE_BITS-1:0]  live_count;

    ohm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ohm_dp #(
        .MAX_BITS   (MAX_BITS),
        .START_BITS (START_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_op      (s_axis_tuser),
        .in_key     (s_axis_tdata[KEY_BITS-1:0]),
        .in_value   (s_axis_tdata[IN_DATA_BITS-1:KEY_BITS]),
        .cmd        (cmd),
        .stat       (stat),
        .found      (found),
        .value_out  (value_out),
        .status     (m_axis_tuser),
        .live_count (live_count)
    );

    assign m_axis_tdata = {{(OUT_DATA_BITS-OUT_USED_BITS){1'b0}}, live_count, value_out, found};

`ifndef ASSERT_OFF
    // at most one slot write per cycle
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_wr, cmd.wr_free, cmd.wr_dead, cmd.wr_live, cmd.wr_update}))
        else $error("conflicting slot writes");

    // no request taken during a clearing pass
    a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    // live count never exceeds the largest table
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(live_count) <= (1 << TBITS)))
        else $error("live count out of range");

    // key zero answers never report found
    a_zero_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_KEY_ZERO) |-> !found)
        else $error("found set on key zero answer");
`endif

endmodule

/* sim/open_addressing_hash_map_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench of open_addressing_hash_map_unit: directed table plus random traffic,
// checked against a behavioral model of the map. Depends on ohm_pkg and the unit.
module open_addressing_hash_map_unit_tb;
    import ohm_pkg::*;

    localparam int MAXB   = DEF_MAX_BITS;
    localparam int STARTB = DEF_START_BITS;
    localparam int NSLOT  = 1 << MAXB;
    localparam int N_RANDOM = 1140;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] value_out;
        status_t               status;
        logic [LIVE_BITS-1:0]  live_count;
    } result_t;

    typedef struct {
        op_t                   op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        bit                    typed;   // result given by hand
        result_t               res;
    } vector_t;

    logic clk, rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [IN_DATA_BITS-1:0] s_axis_tdata;
    logic [OP_BITS-1:0] s_axis_tuser;
    logic m_axis_tvalid, m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [STATUS_BITS-1:0] m_axis_tuser;
    logic cfg_valid, cfg_ready;
    logic [MULT_BITS-1:0] cfg_data;

    open_addressing_hash_map_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Shadow map
    logic [MULT_BITS-1:0]  mdl_mult;
    logic [KEY_BITS-1:0]   mdl_key [2][NSLOT];
    logic [VALUE_BITS-1:0] mdl_val [2][NSLOT];
    tag_t                  mdl_tag [2][NSLOT];
    int                    mdl_bank, mdl_bits, mdl_used, mdl_dead;

    result_t pending_results[$];
    int  errors = 0;
    int  n_sent = 0, n_checked = 0, n_grow = 0, n_full = 0;
    bit  rx_stall_on = 1;
    logic [KEY_BITS-1:0] key_pool[$];

    function automatic int home_of(logic [KEY_BITS-1:0] k, int bits);
        logic [63:0] prod;
        prod = {32'd0, k} * mdl_mult;
        return int'(prod >> (64 - bits));
    endfunction

    function automatic int locate(logic [KEY_BITS-1:0] k);
        int sz, i;
        sz = 1 << mdl_bits;
        i = home_of(k, mdl_bits) & (sz - 1);
        for (int n = 0; n < sz; n++)
        begin
            if (mdl_tag[mdl_bank][i] == TAG_EMPTY) return -1;
            if (mdl_tag[mdl_bank][i] == TAG_LIVE && mdl_key[mdl_bank][i] == k) return i;
            i = (i + 1) & (sz - 1);
        end
        return -1;
    endfunction

    function automatic void store_new(int b, int bits, logic [KEY_BITS-1:0] k,
                                      logic [VALUE_BITS-1:0] v);
        int sz, i;
        sz = 1 << bits;
        i = home_of(k, bits) & (sz - 1);
        for (int n = 0; n < sz; n++)
        begin
            if (mdl_tag[b][i] != TAG_LIVE)
            begin
                if (mdl_tag[b][i] == TAG_DEAD && mdl_dead > 0) mdl_dead--;
                mdl_tag[b][i] = TAG_LIVE;
                mdl_key[b][i] = k;
                mdl_val[b][i] = v;
                mdl_used++;
                return;
            end
            i = (i + 1) & (sz - 1);
        end
    endfunction

    function automatic void rebuild(int bits);
        int src, dst, old_sz;
        src = mdl_bank;
        dst = src ^ 1;
        old_sz = 1 << mdl_bits;
        for (int i = 0; i < NSLOT; i++) mdl_tag[dst][i] = TAG_EMPTY;
        mdl_used = 0;
        mdl_dead = 0;
        for (int i = 0; i < old_sz; i++)
            if (mdl_tag[src][i] == TAG_LIVE)
                store_new(dst, bits, mdl_key[src][i], mdl_val[src][i]);
        mdl_bank = dst;
        mdl_bits = bits;
        n_grow++;
    endfunction

    // Growth / tombstone sweep; 0 when growth is needed at the largest size
    function automatic bit tidy(int extra);
        int sz, u;
        sz = 1 << mdl_bits;
        u = mdl_used + extra;
        if (u * 3 >= sz * 2)
        begin
            if (mdl_bits >= MAXB) return 0;
            rebuild(mdl_bits + 1);
        end
        else if (mdl_dead != 0 && mdl_dead >= u)
            rebuild(mdl_bits);
        return 1;
    endfunction

    function automatic void map_clear();
        for (int b = 0; b < 2; b++)
            for (int i = 0; i < NSLOT; i++) mdl_tag[b][i] = TAG_EMPTY;
        mdl_bank = 0;
        mdl_bits = STARTB;
        mdl_used = 0;
        mdl_dead = 0;
    endfunction

    function automatic result_t map_apply(op_t op, logic [KEY_BITS-1:0] k,
                                          logic [VALUE_BITS-1:0] v);
        result_t r;
        int pos;
        r = '0;
        r.status = ST_OK;
        if (op == OP_CLEAR)
            map_clear();
        else if (k == 0)
            r.status = ST_KEY_ZERO;
        else
        begin
            pos = locate(k);
            r.found = (pos >= 0);
            if (op == OP_LOOKUP)
            begin
                if (pos >= 0) r.value_out = mdl_val[mdl_bank][pos];
            end
            else if (op == OP_INSERT)
            begin
                if (pos >= 0)
                    mdl_val[mdl_bank][pos] = v;
                else if (!tidy(1))
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
                else
                    store_new(mdl_bank, mdl_bits, k, v);
            end
            else if (pos >= 0)
            begin
                mdl_tag[mdl_bank][pos] = TAG_DEAD;
                mdl_val[mdl_bank][pos] = '0;
                if (mdl_used > 0) mdl_used--;
                mdl_dead++;
                void'(tidy(0));
            end
        end
        r.live_count = mdl_used[LIVE_BITS-1:0];
        return r;
    endfunction

    // Clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Result checker with its own stall pattern
    always @(posedge clk)
    begin
        result_t got, exp_r;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.found      = m_axis_tdata[0];
            got.value_out  = m_axis_tdata[VALUE_BITS:1];
            got.live_count = m_axis_tdata[VALUE_BITS+LIVE_BITS:VALUE_BITS+1];
            got.status     = status_t'(m_axis_tuser);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (got.found !== exp_r.found)
                begin
                    $display("%0t: found expected %0d actual %0d", $time, exp_r.found, got.found);
                    errors++;
                end
                if (got.value_out !== exp_r.value_out)
                begin
                    $display("%0t: value_out expected %h actual %h", $time,
                             exp_r.value_out, got.value_out);
                    errors++;
                end
                if (got.status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, got.status);
                    errors++;
                end
                if (got.live_count !== exp_r.live_count)
                begin
                    $display("%0t: live_count expected %0d actual %0d", $time,
                             exp_r.live_count, got.live_count);
                    errors++;
                end
            end
        end
        if (rst_n)
            m_axis_tready <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // Send one request in a burst; optional idle cycles after it
    task automatic send_req(op_t op, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v,
                            int idle_after, bit typed, result_t hand);
        result_t pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {v, k};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pred = map_apply(op, k, v);
        if (typed && pred !== hand)
        begin
            $display("%0t: table row disagrees, expected %h predicted %h", $time, hand, pred);
            errors++;
        end
        pending_results.push_back(typed ? hand : pred);
        n_sent++;
        if (idle_after > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle_after) @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_mult(logic [MULT_BITS-1:0] m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        mdl_mult = m;
    endtask

    function automatic result_t mk(bit f, logic [VALUE_BITS-1:0] v, status_t s, int live);
        result_t r;
        r.found = f;
        r.value_out = v;
        r.status = s;
        r.live_count = live[LIVE_BITS-1:0];
        return r;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom_range(0, 15) == 0 ? '0 : $urandom();
    endfunction

    // Random phase; key pool sized to drive the table near a target load
    task automatic random_phase(int count, int pool_sz, bit quiet);
        logic [KEY_BITS-1:0] k;
        int burst;
        op_t op;
        key_pool.delete();
        for (int i = 0; i < pool_sz; i++) key_pool.push_back($urandom() | 32'h1);
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = OP_INSERT;
                4, 5:       op = OP_LOOKUP;
                6, 7, 8:    op = OP_REMOVE;
                default:    op = ($urandom_range(0, 20) == 0) ? OP_CLEAR : OP_LOOKUP;
            endcase
            k = pick_key();
            if (burst == 0) burst = $urandom_range(1, 12);
            burst--;
            send_req(op, k, $urandom(),
                     (quiet || burst != 0) ? 0 : $urandom_range(1, 6), 0, '0);
        end
    endtask

    vector_t dir_table[$];

    initial
    begin
        // directed rows: op, key, value, typed, result
        dir_table.push_back('{OP_LOOKUP, 32'd5, 32'd0, 1, mk(0, 0, ST_OK, 0)});
        dir_table.push_back('{OP_INSERT, 32'd0, 32'hFFFF_FFFF, 1, mk(0, 0, ST_KEY_ZERO, 0)});
        dir_table.push_back('{OP_LOOKUP, 32'd0, 32'd0, 1, mk(0, 0, ST_KEY_ZERO, 0)});
        dir_table.push_back('{OP_REMOVE, 32'd0, 32'd0, 1, mk(0, 0, ST_KEY_ZERO, 0)});
        dir_table.push_back('{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, mk(0, 0, ST_OK, 1)});
        dir_table.push_back('{OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1,
                              mk(1, 32'hFFFF_FFFF, ST_OK, 1)});
        dir_table.push_back('{OP_INSERT, 32'h1, 32'h0, 1, mk(0, 0, ST_OK, 2)});
        dir_table.push_back('{OP_INSERT, 32'h1, 32'hA5A5_5A5A, 1, mk(1, 0, ST_OK, 2)});
        dir_table.push_back('{OP_LOOKUP, 32'h1, 32'd0, 1, mk(1, 32'hA5A5_5A5A, ST_OK, 2)});
        dir_table.push_back('{OP_INSERT, 32'h8000_0000, 32'h1, 0, '0});
        dir_table.push_back('{OP_INSERT, 32'h5555_5555, 32'h2, 0, '0});
        dir_table.push_back('{OP_INSERT, 32'hAAAA_AAAA, 32'h3, 0, '0});
        dir_table.push_back('{OP_REMOVE, 32'h1, 32'd0, 0, '0});
        dir_table.push_back('{OP_REMOVE, 32'h1, 32'd0, 0, '0});
        dir_table.push_back('{OP_LOOKUP, 32'h8000_0000, 32'd0, 0, '0});
        dir_table.push_back('{OP_REMOVE, 32'h5555_5555, 32'd0, 0, '0});
        dir_table.push_back('{OP_INSERT, 32'h1234_5678, 32'h8765_4321, 0, '0});
        dir_table.push_back('{OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, mk(0, 0, ST_OK, 0)});
        dir_table.push_back('{OP_LOOKUP, 32'h1234_5678, 32'd0, 1, mk(0, 0, ST_OK, 0)});

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOOKUP;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        mdl_mult  = MULT_RESET;
        map_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset multiplier
        foreach (dir_table[i])
            send_req(dir_table[i].op, dir_table[i].key, dir_table[i].value,
                     $urandom_range(0, 2), dir_table[i].typed, dir_table[i].res);
        drain_and_settle();

        // Sender holds off until everything is answered
        send_req(OP_INSERT, 32'hDEAD_BEEF, 32'h1, 0, 0, '0);
        drain_and_settle();

        // Fill to the largest size until the table has reported full three times
        rx_stall_on = 0;
        while (n_full < 3)
            send_req(OP_INSERT, $urandom() | 32'h1, $urandom(), 0, 0, '0);
        send_req(OP_REMOVE, key_pool.size() != 0 ? key_pool[0] : 32'h7, 32'd0, 0, 0, '0);
        send_req(OP_CLEAR, 32'd0, 32'd0, 0, 0, '0);
        drain_and_settle();
        rx_stall_on = 1;

        // Multiplier extremes, then random traffic
        write_mult(64'h0);
        random_phase(120, 6, 0);
        drain_and_settle();
        write_mult(64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(200, 40, 0);
        drain_and_settle();
        write_mult(64'h1);
        random_phase(120, 8, 0);
        drain_and_settle();
        write_mult({$urandom(), $urandom()} | 64'h1);
        random_phase(300, 120, 0);
        drain_and_settle();
        write_mult(MULT_RESET);
        rx_stall_on = 0;
        random_phase(150, 30, 1);
        rx_stall_on = 1;
        random_phase(N_RANDOM - 890, 300, 0);
        drain_and_settle();

        $display("Run: %0d requests, %0d results checked, %0d rehashes, %0d full answers",
                 n_sent, n_checked, n_grow, n_full);
        $display("Multipliers covered zero, all ones, one, random and reset value");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/ohm_pkg.sv
hw/rtl/ohm_ram.sv
hw/rtl/ohm_dp.sv
hw/rtl/ohm_ctrl.sv
hw/rtl/open_addressing_hash_map_unit.sv
sim/open_addressing_hash_map_unit_tb.sv
